@@ rtl/core/md5_pkg.sv @@
package md5_pkg;

  localparam int LENGTH_COUNT_WIDTH = 61;

  typedef logic [31:0] word_t;
  typedef logic [LENGTH_COUNT_WIDTH-1:0] count_t;

  localparam word_t INIT_A = 32'h67452301;
  localparam word_t INIT_B = 32'hEFCDAB89;
  localparam word_t INIT_C = 32'h98BADCFE;
  localparam word_t INIT_D = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // round constants, floor(abs(sin(i + 1)) * 2^32)
  function automatic word_t sine_k(input logic [5:0] s);
    word_t k;
    case (s)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] s);
    logic [4:0] r;
    case ({s[5:4], s[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word used at step s
  function automatic logic [3:0] msg_idx(input logic [5:0] s);
    logic [3:0] k;
    logic [3:0] g;
    k = s[3:0];
    case (s[5:4])
      2'd0: g = k;
      2'd1: g = 4'((k << 2) + k + 4'd1);
      2'd2: g = 4'((k << 1) + k + 4'd5);
      default: g = 4'((k << 3) - k);
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic       start;   // run the block held in the buffer
    logic       busy;
  } blk_ctl_t;

endpackage

@@ rtl/core/md5_if.sv @@
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/md5_message_digest_core.sv @@
// channel | dir | payload
// in      | in  | data_byte[7:0], has_byte, end_of_message
// out     | out | digest_word[31:0], word_index[1:0], last_word
// one byte item per cycle while a block fills; a full block then holds input off
// while the step unit runs 64 steps off the block memory, then adds up
// a message end pads at one byte per cycle, up to two blocks, then gives 4 items
// rst_n is synchronous: chaining words to the standard initial values, count zero
// out stalls hold the word on the port; input stays off until all 4 items leave
module md5_message_digest_core (
  input  logic      clk,
  input  logic      rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BLK  = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]  state_r, state_nxt;
  count_t      cnt_r, cnt_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        pad_r, pad_nxt;       // end pending; while padding, high once the 0x80 byte is placed
  logic        lenb_r, lenb_nxt;     // the block now running carries the length
  logic        spill_r, spill_nxt;   // 0x80 landed too late, length goes in the next block
  logic [23:0] acc_r, acc_nxt;       // low bytes of the word being packed
  word_t       h_r [4];
  word_t       sum [4];
  logic [1:0]  oidx_r, oidx_nxt;
  logic        byte_en;
  logic [7:0]  byte_val;
  logic [63:0] bits;
  logic        wr_en;
  word_t       wr_data;
  blk_ctl_t    ctl;
  logic        done, busy;
  logic        take;

  assign bits = 64'({cnt_r, 3'b000});
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == ST_IDLE;

  always_comb begin
    byte_en = 1'b0;
    byte_val = in_ch.data_byte;
    if (state_r == ST_IDLE && take && in_ch.has_byte) begin
      byte_en = 1'b1;
    end else if (state_r == ST_PAD) begin
      byte_en = 1'b1;
      if (!pad_r) begin
        byte_val = PAD_BYTE;
      end else if (pos_r >= 6'd56 && !spill_r) begin
        byte_val = bits[{pos_r[2:0], 3'b000} +: 8];
      end else begin
        byte_val = 8'h00;
      end
    end
    wr_en = byte_en && pos_r[1:0] == 2'd3;
    wr_data = {byte_val, acc_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    pad_nxt = pad_r;
    lenb_nxt = lenb_r;
    spill_nxt = spill_r;
    acc_nxt = acc_r;
    oidx_nxt = oidx_r;
    ctl.start = 1'b0;
    ctl.busy = busy;
    if (byte_en) begin
      acc_nxt = {byte_val, acc_r[23:8]};
      pos_nxt = 6'(pos_r + 6'd1);
    end
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_ch.has_byte) begin
            cnt_nxt = count_t'(cnt_r + 1'b1);
          end
          if (byte_en && pos_r == 6'd63) begin
            ctl.start = 1'b1;
            state_nxt = ST_BLK;
            pad_nxt = in_ch.end_of_message;
            lenb_nxt = 1'b0;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
            pad_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        // pad_r low on the 0x80 byte only
        pad_nxt = 1'b1;
        if (!pad_r && pos_r >= 6'd56) begin
          spill_nxt = 1'b1;
        end
        if (pos_r == 6'd63) begin
          ctl.start = 1'b1;
          state_nxt = ST_BLK;
          lenb_nxt = !spill_nxt;
        end
      end
      ST_BLK: begin
        if (done) begin
          if (lenb_r) begin
            state_nxt = ST_OUT;
            oidx_nxt = '0;
          end else if (spill_r) begin
            // zero fill and length, 0x80 already placed
            state_nxt = ST_PAD;
            spill_nxt = 1'b0;
          end else if (pad_r) begin
            state_nxt = ST_PAD;
            pad_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          oidx_nxt = 2'(oidx_r + 2'd1);
          if (oidx_r == 2'd3) begin
            state_nxt = ST_IDLE;
            cnt_nxt = '0;
            pad_nxt = 1'b0;
            lenb_nxt = 1'b0;
            spill_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      pos_r <= '0;
      pad_r <= 1'b0;
      lenb_r <= 1'b0;
      spill_r <= 1'b0;
      oidx_r <= '0;
      h_r[0] <= INIT_A;
      h_r[1] <= INIT_B;
      h_r[2] <= INIT_C;
      h_r[3] <= INIT_D;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      pad_r <= pad_nxt;
      lenb_r <= lenb_nxt;
      spill_r <= spill_nxt;
      oidx_r <= oidx_nxt;
      if (state_r == ST_OUT && out_ch.ready && oidx_r == 2'd3) begin
        h_r[0] <= INIT_A;
        h_r[1] <= INIT_B;
        h_r[2] <= INIT_C;
        h_r[3] <= INIT_D;
      end else if (done) begin
        h_r <= sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  md5_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .done_o    (done),
    .busy_o    (busy),
    .h_i       (h_r),
    .sum_o     (sum),
    .wr_en_i   (wr_en),
    .wr_addr_i (pos_r[5:2]),
    .wr_data_i (wr_data)
  );

  assign out_ch.valid = state_r == ST_OUT;
  assign out_ch.digest_word = h_r[oidx_r];
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = oidx_r == 2'd3;

endmodule

@@ rtl/core/md5_round.sv @@
// 64-step compression over a 16-word block memory, one step per cycle;
// the memory read for step s+1 is issued during step s
module md5_round (
  input  logic                clk,
  input  logic                rst_n,
  input  md5_pkg::blk_ctl_t   ctl_i,
  output logic                done_o,
  output logic                busy_o,
  input  md5_pkg::word_t      h_i [4],
  output md5_pkg::word_t      sum_o [4],
  input  logic                wr_en_i,
  input  logic [3:0]          wr_addr_i,
  input  md5_pkg::word_t      wr_data_i
);
  import md5_pkg::*;

  word_t      mem [16];
  word_t      rd_data_r;
  logic [5:0] step_r, step_nxt;
  logic       run_r, run_nxt;
  logic       fin_r;
  word_t      a_r, b_r, c_r, d_r;
  word_t      f, x, b_new;
  logic [5:0] rd_step;
  logic [4:0] sh;

  assign rd_step = ctl_i.start ? 6'd0 : 6'(step_r + 6'd1);

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_r <= mem[msg_idx(rd_step)];
  end

  always_comb begin
    case (step_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    x = a_r + f + sine_k(step_r) + rd_data_r;
    sh = rot_amt(step_r);
    b_new = b_r + ((x << sh) | (x >> (6'd32 - {1'b0, sh})));
  end

  always_comb begin
    run_nxt = run_r;
    step_nxt = step_r;
    if (ctl_i.start) begin
      run_nxt = 1'b1;
      step_nxt = '0;
    end else if (run_r) begin
      step_nxt = 6'(step_r + 6'd1);
      if (step_r == 6'd63) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      step_r <= '0;
      fin_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      step_r <= step_nxt;
      fin_r <= run_r && step_r == 6'd63;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      a_r <= h_i[0];
      b_r <= h_i[1];
      c_r <= h_i[2];
      d_r <= h_i[3];
    end else if (run_r) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_new;
    end
  end

  assign done_o = fin_r;
  assign busy_o = run_r | fin_r;
  assign sum_o[0] = h_i[0] + a_r;
  assign sum_o[1] = h_i[1] + b_r;
  assign sum_o[2] = h_i[2] + c_r;
  assign sum_o[3] = h_i[3] + d_r;

endmodule
